// ===== rtl/core/pali_pkg.sv =====
// ----------------------------------------------------------------------------
// pali_pkg: shared types and constants of the arc-length integrand
// Field widths, fixed-point layout, register indexes and the structs that
// travel between the slope pipeline and the square-root pipeline.
// ----------------------------------------------------------------------------
package pali_pkg;

  // Field widths
  localparam int unsigned Y_W    = 32;          // position, Q15.16
  localparam int unsigned YP_W   = Y_W + 1;     // position minus origin, exact
  localparam int unsigned CNT_W  = 3;           // coefficient count
  localparam int unsigned COEF_W = 48;          // coefficient registers
  localparam int unsigned C2_W   = COEF_W + 1;  // 2 * C2
  localparam int unsigned C3_W   = COEF_W + 2;  // 3 * C3
  localparam int unsigned C4_W   = COEF_W + 2;  // 4 * C4
  localparam int unsigned IDX_W  = 3;           // register index
  localparam int unsigned CFG_W  = COEF_W;      // register write data

  // Fixed-point layout
  localparam int unsigned U_FRAC   = 26;        // fraction bits of the scaled offset
  localparam int unsigned OUT_W    = 48;        // result, unsigned Q16.32
  localparam int unsigned OUT_FRAC = 32;
  localparam int unsigned M_W      = OUT_W;     // slope magnitude, Q16.32

  // Parameter defaults
  localparam int unsigned FRAC_BITS_DEF = 40;
  localparam int unsigned MAX_TERMS_DEF = 5;

  // Result value 1.0
  localparam logic [OUT_W-1:0] RATE_ONE = OUT_W'(1) << OUT_FRAC;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_COEFF_COUNT   = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_SLOPE_COEFF   = 3'd2,
    REG_SQUARE_COEFF  = 3'd3,
    REG_CUBE_COEFF    = 3'd4,
    REG_QUARTIC_COEFF = 3'd5
  } cfg_reg_e;

  // Coefficients with their Horner weights, zero where the count drops them
  typedef struct packed {
    logic signed [COEF_W-1:0] c1;
    logic signed [C2_W-1:0]   c2x2;
    logic signed [C3_W-1:0]   c3x3;
    logic signed [C4_W-1:0]   c4x4;
  } coef_t;

  // Slope magnitude handed to the root pipeline
  typedef struct packed {
    logic           valid;
    logic           sat;
    logic [M_W-1:0] mag;
  } slope_t;

endpackage

// ===== rtl/core/pali_if.sv =====
// ----------------------------------------------------------------------------
// pali_if: handshake channels of the arc-length integrand
// Position input, rate output and register write channel, each with valid,
// ready and its payload.
// ----------------------------------------------------------------------------

// Position channel
interface pali_in_if;
  import pali_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [Y_W-1:0] y_pos;

  modport source (output valid, output y_pos, input ready);
  modport sink (input valid, input y_pos, output ready);
endinterface

// Rate channel
interface pali_out_if;
  import pali_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] path_rate;

  modport source (output valid, output path_rate, input ready);
  modport sink (input valid, input path_rate, output ready);
endinterface

// Register write channel
interface pali_cfg_if;
  import pali_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] reg_index;
  logic [CFG_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/core/pali_slope.sv =====
// ----------------------------------------------------------------------------
// pali_slope: slope evaluation pipeline
// Eight register stages: offset from origin, three Horner steps each split
// into a partial-product stage and an add stage, then magnitude and
// truncation to Q16.32 with a saturation flag.
// ----------------------------------------------------------------------------
module pali_slope #(
  parameter int unsigned FRAC_BITS = pali_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [pali_pkg::Y_W-1:0] y_pos_i,
  input  logic signed [pali_pkg::Y_W-1:0] origin_y_i,
  input  pali_pkg::coef_t               coef_i,
  output pali_pkg::slope_t              slope_o
);
  import pali_pkg::*;

  // Widths of the Horner steps
  localparam int unsigned C4_LO   = C4_W / 2;
  localparam int unsigned C4_HI   = C4_W - C4_LO;
  localparam int unsigned P1L_W   = YP_W + C4_LO + 1;
  localparam int unsigned P1H_W   = YP_W + C4_HI;
  localparam int unsigned S2_W    = YP_W + C4_W;
  localparam int unsigned INNER_W = S2_W - U_FRAC;
  localparam int unsigned IN_LO   = (INNER_W + 1) / 2;
  localparam int unsigned IN_HI   = INNER_W - IN_LO;
  localparam int unsigned P3L_W   = YP_W + IN_LO + 1;
  localparam int unsigned P3H_W   = YP_W + IN_HI;
  localparam int unsigned S4_W    = YP_W + INNER_W + 1;
  localparam int unsigned MID_W   = S4_W - U_FRAC - 1;
  localparam int unsigned MID_LO  = MID_W / 2;
  localparam int unsigned MID_HI  = MID_W - MID_LO;
  localparam int unsigned P5L_W   = YP_W + MID_LO + 1;
  localparam int unsigned P5H_W   = YP_W + MID_HI;
  localparam int unsigned ACC_W   = YP_W + MID_W;
  localparam int unsigned M_LSB   = FRAC_BITS + U_FRAC - OUT_FRAC;
  localparam int unsigned SAT_LSB = M_LSB + M_W;

  // Stage registers
  logic                     s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  logic signed [YP_W-1:0]   s0_yp_q, s1_yp_q, s2_yp_q, s3_yp_q, s4_yp_q;
  logic signed [P1L_W-1:0]  s1_plo_q;
  logic signed [P1H_W-1:0]  s1_phi_q;
  logic signed [INNER_W-1:0] s2_inner_q;
  logic signed [P3L_W-1:0]  s3_plo_q;
  logic signed [P3H_W-1:0]  s3_phi_q;
  logic signed [MID_W-1:0]  s4_mid_q;
  logic signed [P5L_W-1:0]  s5_plo_q;
  logic signed [P5H_W-1:0]  s5_phi_q;
  logic signed [ACC_W-1:0]  s6_acc_q;
  logic                     s7_sat_q;
  logic [M_W-1:0]           s7_mag_q;

  // Stage logic
  logic signed [YP_W-1:0]   s0_yp_d;
  logic signed [P1L_W-1:0]  s1_plo_d;
  logic signed [P1H_W-1:0]  s1_phi_d;
  logic signed [S2_W-1:0]   s2_sum;
  logic signed [P3L_W-1:0]  s3_plo_d;
  logic signed [P3H_W-1:0]  s3_phi_d;
  logic signed [S4_W-1:0]   s4_sum;
  logic signed [P5L_W-1:0]  s5_plo_d;
  logic signed [P5H_W-1:0]  s5_phi_d;
  logic signed [ACC_W-1:0]  s6_acc_d;
  logic signed [ACC_W-1:0]  s7_neg;
  logic [ACC_W-2:0]         s7_abs;

  // Offset from origin, exact in one extra bit
  assign s0_yp_d = YP_W'(y_pos_i) - YP_W'(origin_y_i);

  // First step: offset times 4*C4, split into two partial products
  assign s1_plo_d = s0_yp_q * $signed({1'b0, coef_i.c4x4[C4_LO-1:0]});
  assign s1_phi_d = s0_yp_q * $signed(coef_i.c4x4[C4_W-1:C4_LO]);

  // Combine, add 3*C3 ahead of the scale, drop the fraction
  assign s2_sum = (S2_W'(s1_phi_q) <<< C4_LO) + S2_W'(s1_plo_q)
                + (S2_W'($signed(coef_i.c3x3)) <<< U_FRAC);

  // Second step: offset times the inner term
  assign s3_plo_d = s2_yp_q * $signed({1'b0, s2_inner_q[IN_LO-1:0]});
  assign s3_phi_d = s2_yp_q * $signed(s2_inner_q[INNER_W-1:IN_LO]);

  assign s4_sum = (S4_W'(s3_phi_q) <<< IN_LO) + S4_W'(s3_plo_q)
                + (S4_W'($signed(coef_i.c2x2)) <<< U_FRAC);

  // Third step: offset times the middle term, kept exact
  assign s5_plo_d = s4_yp_q * $signed({1'b0, s4_mid_q[MID_LO-1:0]});
  assign s5_phi_d = s4_yp_q * $signed(s4_mid_q[MID_W-1:MID_LO]);

  assign s6_acc_d = (ACC_W'(s5_phi_q) <<< MID_LO) + ACC_W'(s5_plo_q)
                  + (ACC_W'($signed(coef_i.c1)) <<< U_FRAC);

  // Magnitude of the slope
  assign s7_neg = -s6_acc_q;
  assign s7_abs = s6_acc_q[ACC_W-1] ? s7_neg[ACC_W-2:0] : s6_acc_q[ACC_W-2:0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en_i) begin
      s0_v_q <= valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_yp_q    <= s0_yp_d;
      s1_yp_q    <= s0_yp_q;
      s1_plo_q   <= s1_plo_d;
      s1_phi_q   <= s1_phi_d;
      s2_yp_q    <= s1_yp_q;
      s2_inner_q <= s2_sum[U_FRAC +: INNER_W];
      s3_yp_q    <= s2_yp_q;
      s3_plo_q   <= s3_plo_d;
      s3_phi_q   <= s3_phi_d;
      s4_yp_q    <= s3_yp_q;
      s4_mid_q   <= s4_sum[U_FRAC +: MID_W];
      s5_plo_q   <= s5_plo_d;
      s5_phi_q   <= s5_phi_d;
      s6_acc_q   <= s6_acc_d;
      s7_sat_q   <= |s7_abs[ACC_W-2:SAT_LSB];
      s7_mag_q   <= s7_abs[M_LSB +: M_W];
    end
  end

  assign slope_o = '{valid: s7_v_q, sat: s7_sat_q, mag: s7_mag_q};

endmodule

// ===== rtl/core/pali_root.sv =====
// ----------------------------------------------------------------------------
// pali_root: square and square-root pipeline
// Squares the Q16.32 slope magnitude, adds 1.0, then takes the integer root
// one bit per stage and clamps the result to the output width.
// ----------------------------------------------------------------------------
module pali_root (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  pali_pkg::slope_t          slope_i,
  output logic                      valid_o,
  output logic [pali_pkg::OUT_W-1:0] path_rate_o
);
  import pali_pkg::*;

  localparam int unsigned M_HALF = M_W / 2;
  localparam int unsigned PP_W   = 2 * M_HALF;
  localparam int unsigned ROOT_W = OUT_W + 1;
  localparam int unsigned X_W    = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;

  // Partial products of the square
  logic            sq_v_q;
  logic            sq_sat_q;
  logic [PP_W-1:0] sq_hh_q, sq_hl_q, sq_ll_q;

  // Root digit stages; stage zero holds the radicand
  logic              v_q    [0:ROOT_W];
  logic              sat_q  [0:ROOT_W];
  logic [X_W-1:0]    x_q    [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_q  [1:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [1:ROOT_W];

  logic [X_W-1:0] x_d;

  // Radicand: 1.0 squared plus the slope squared
  assign x_d = (X_W'(1) << (2 * OUT_FRAC)) + (X_W'(sq_hh_q) << M_W)
             + (X_W'(sq_hl_q) << (M_HALF + 1)) + X_W'(sq_ll_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_v_q <= slope_i.valid;
      v_q[0] <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_sat_q <= slope_i.sat;
      sq_hh_q  <= slope_i.mag[M_W-1:M_HALF] * slope_i.mag[M_W-1:M_HALF];
      sq_hl_q  <= slope_i.mag[M_W-1:M_HALF] * slope_i.mag[M_HALF-1:0];
      sq_ll_q  <= slope_i.mag[M_HALF-1:0] * slope_i.mag[M_HALF-1:0];
      sat_q[0] <= sq_sat_q;
      x_q[0]   <= x_d;
    end
  end

  // One root bit per stage, restoring form
  for (genvar j = 1; j <= ROOT_W; j++) begin : g_digit
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;

    if (j == 1) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign rem_prev  = rem_q[j-1];
      assign root_prev = root_q[j-1];
    end

    // Bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_prev, x_q[j-1][X_W-1 -: 2]};
    assign trial  = {2'b00, root_prev, 2'b01};
    assign diff   = rem_sh - trial;
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[j]  <= sat_q[j-1];
        root_q[j] <= {root_prev[ROOT_W-2:0], take};
      end
    end

    if (j < ROOT_W) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
          x_q[j]   <= {x_q[j-1][X_W-3:0], 2'b00};
        end
      end
    end
  end

  // Clamp on slope overflow or a root of 2^48 or more
  assign valid_o     = v_q[ROOT_W];
  assign path_rate_o = (sat_q[ROOT_W] || root_q[ROOT_W][ROOT_W-1]) ? '1
                     : root_q[ROOT_W][OUT_W-1:0];

endmodule

// ===== rtl/core/polynomial_arc_length_integrand.sv =====
// ----------------------------------------------------------------------------
// polynomial_arc_length_integrand: ds/dy of a polynomial curve x(y)
// Returns sqrt(1 + (dx/dy)^2) in unsigned Q16.32 for each position, with the
// slope polynomial of degree up to three taken from configured coefficients.
//
//   channel  dir  payload                    handshake
//   cfg_i    in   reg_index[2:0], wdata[47:0] valid/ready, ready always high
//   pos_i    in   y_pos[31:0] signed Q15.16   valid/ready
//   rate_o   out  path_rate[47:0] Q16.32      valid/ready
//
// One position per cycle while the skid register is empty; a result passes
// the eight slope and two square stages, the 49 root-bit stages and the
// output register.
// Reset clears every valid bit and the configuration registers; coefficients
// reset to zero. Datapath registers are not reset.
// A stalled output fills a one-item skid register, which freezes the whole
// pipeline while it holds the item; input ready comes from that register alone.
// ----------------------------------------------------------------------------
module polynomial_arc_length_integrand #(
  parameter int unsigned FRAC_BITS = pali_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAX_TERMS = pali_pkg::MAX_TERMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pali_cfg_if.sink    cfg_i,
  pali_in_if.sink     pos_i,
  pali_out_if.source  rate_o
);
  import pali_pkg::*;

  localparam logic [CNT_W-1:0] TERMS_LINEAR  = CNT_W'(3);
  localparam logic [CNT_W-1:0] TERMS_CUBIC   = CNT_W'(4);
  localparam logic [CNT_W-1:0] TERMS_QUARTIC = CNT_W'(5);
  localparam logic [CNT_W-1:0] TERMS_MAX     = CNT_W'(MAX_TERMS);

  // Configuration registers
  logic [CNT_W-1:0]         count_q;
  logic signed [Y_W-1:0]    origin_q;
  logic signed [COEF_W-1:0] slope_q, square_q, cube_q, quartic_q;

  logic [CNT_W-1:0] terms;
  coef_t            coef;

  // Pipeline and output side
  logic             en;
  slope_t           slope;
  logic             root_valid;
  logic [OUT_W-1:0] root_rate;
  logic             push;
  logic             out_free;

  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;
  logic             skid_valid_q, skid_valid_d;
  logic [OUT_W-1:0] skid_data_q, skid_data_d;

  // Take register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      origin_q  <= '0;
      slope_q   <= '0;
      square_q  <= '0;
      cube_q    <= '0;
      quartic_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        REG_COEFF_COUNT:   count_q   <= cfg_i.wdata[CNT_W-1:0];
        REG_ORIGIN_Y:      origin_q  <= cfg_i.wdata[Y_W-1:0];
        REG_SLOPE_COEFF:   slope_q   <= cfg_i.wdata[COEF_W-1:0];
        REG_SQUARE_COEFF:  square_q  <= cfg_i.wdata[COEF_W-1:0];
        REG_CUBE_COEFF:    cube_q    <= cfg_i.wdata[COEF_W-1:0];
        REG_QUARTIC_COEFF: quartic_q <= cfg_i.wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Weight coefficients and drop the terms beyond the count
  assign terms = (count_q > TERMS_MAX) ? TERMS_MAX : count_q;

  always_comb begin
    coef = '0;
    if (terms >= TERMS_LINEAR) begin
      coef.c1   = slope_q;
      coef.c2x2 = C2_W'(square_q) <<< 1;
    end
    if (terms >= TERMS_CUBIC) begin
      coef.c3x3 = C3_W'(cube_q) + (C3_W'(cube_q) <<< 1);
    end
    if (terms >= TERMS_QUARTIC) begin
      coef.c4x4 = C4_W'(quartic_q) <<< 2;
    end
  end

  // Freeze the pipeline while the skid register holds an item
  assign en         = !skid_valid_q;
  assign pos_i.ready = en;

  pali_slope #(
    .FRAC_BITS (FRAC_BITS)
  ) u_slope (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (pos_i.valid),
    .y_pos_i    (pos_i.y_pos),
    .origin_y_i (origin_q),
    .coef_i     (coef),
    .slope_o    (slope)
  );

  pali_root u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .slope_i     (slope),
    .valid_o     (root_valid),
    .path_rate_o (root_rate)
  );

  // Route the leaving item to the output register or the skid register
  assign push     = en && root_valid;
  assign out_free = !out_valid_q || rate_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_data_d  = root_rate;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_data_d  = root_rate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign rate_o.valid     = out_valid_q;
  assign rate_o.path_rate = out_data_q;

  // The skid register only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the output is empty");

  // An item leaving into a stalled output is kept in the skid register
  a_stall_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !rate_o.ready) |=> (skid_valid_q && out_valid_q))
    else $error("item lost at a stalled output");

  // The skid register drains only when the output was taken
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_valid_q) |-> $past(rate_o.ready))
    else $error("skid register emptied without an output transfer");

  // Every result is at least 1.0
  a_rate_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_o.valid |-> (rate_o.path_rate >= RATE_ONE))
    else $error("result below 1.0");

endmodule
